/* src/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants for the indexed shift list
// Field widths, request codes and the control bundle that is broadcast to
// every storage cell of the chain.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             take;
    logic [POS_W-1:0] pos;
  } isl_ctrl_t;

endpackage

/* src/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell: one storage cell of the indexed shift list
// Holds one entry. Takes its left neighbour's word on an insert below it,
// the request word on an insert at it, its right neighbour's word on a
// remove at or below it, and registers its entry onto the tap on a take at it.
// ----------------------------------------------------------------------------
module isl_cell #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  isl_pkg::isl_ctrl_t    ctrl,
  input  logic [ELEM_WIDTH-1:0] value_in,
  input  logic [ELEM_WIDTH-1:0] left_data,
  input  logic [ELEM_WIDTH-1:0] right_data,
  output logic [ELEM_WIDTH-1:0] data,
  output logic [ELEM_WIDTH-1:0] tap
);
  import isl_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;

  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      own_idx;
  logic                  hit;
  logic                  above;
  logic [ELEM_WIDTH-1:0] data_r;
  logic [ELEM_WIDTH-1:0] data_nxt;
  logic [ELEM_WIDTH-1:0] tap_r;
  logic [ELEM_WIDTH-1:0] tap_nxt;

  assign pos_ext = CMP_W'(ctrl.pos);
  assign own_idx = CMP_W'(INDEX);
  assign hit     = (own_idx == pos_ext);
  assign above   = (own_idx > pos_ext);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up && above) begin
      data_nxt = left_data;
    end else if (ctrl.shift_up && hit) begin
      data_nxt = value_in;
    end else if (ctrl.shift_down && (above || hit)) begin
      data_nxt = right_data;
    end
    tap_nxt = (ctrl.take && hit) ? data_r : '0;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data = data_r;
  assign tap  = tap_r;

endmodule

/* src/indexed_shift_list.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list: fixed-capacity ordered list with insert/remove at index
// A request (in_action, in_position, in_value_in) transfers at a rising edge
// with start high and busy low. busy is always low: every entry sits in a cell
// of a chain and all cells shift in the same cycle, so one request can
// transfer on every clock.
// Actions: insert at a position (later entries move up), remove at a position
// (later entries move down, the word is returned), read at a position, clear.
// Each request gives exactly one result in the next cycle: out_strobe is high
// for that single cycle with out_ok, out_value_out and out_count (the count
// after the request). Throughput is one request per cycle.
// Rejected requests leave the list unchanged and return ok low, value zero.
// The receiver cannot stall; results must be taken as they appear.
// Reset (rst_n low, synchronous) empties the list; entries hold no reset
// value and are only read after being written.
// ----------------------------------------------------------------------------
module indexed_shift_list #(
  parameter int CAPACITY   = isl_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = isl_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [isl_pkg::ACTION_W-1:0] in_action,
  input  logic [isl_pkg::POS_W-1:0]    in_position,
  input  logic [isl_pkg::VALUE_W-1:0]  in_value_in,
  output logic                         out_strobe,
  output logic                         out_ok,
  output logic [isl_pkg::VALUE_W-1:0]  out_value_out,
  output logic [isl_pkg::COUNT_W-1:0]  out_count
);
  import isl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic                  accept;
  action_t               action;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  ok;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  strobe_r;
  logic                  ok_r;
  isl_ctrl_t             ctrl;
  logic [ELEM_WIDTH-1:0] elem_in;
  logic [ELEM_WIDTH-1:0] data  [CAPACITY];
  logic [ELEM_WIDTH-1:0] taps  [CAPACITY];
  logic [ELEM_WIDTH-1:0] tap_or;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign action  = action_t'(in_action);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign elem_in = ELEM_WIDTH'(in_value_in);

  always_comb begin
    ok        = 1'b0;
    count_nxt = count_r;
    unique case (action)
      ACT_INSERT: begin
        ok = (count_r < CNT_W'(CAPACITY)) && (pos_ext <= cnt_ext);
        if (ok) begin
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_REMOVE: begin
        ok = (pos_ext < cnt_ext);
        if (ok) begin
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_READ: begin
        ok = (pos_ext < cnt_ext);
      end
      ACT_CLEAR: begin
        ok        = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.pos        = in_position;
    ctrl.shift_up   = accept && ok && (action == ACT_INSERT);
    ctrl.shift_down = accept && ok && (action == ACT_REMOVE);
    ctrl.take       = accept && ok && ((action == ACT_REMOVE) || (action == ACT_READ));
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_w;
    logic [ELEM_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = data[g+1];
    end
    isl_cell #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value_in   (elem_in),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (data[g]),
      .tap        (taps[g])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
      ok_r     <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
        ok_r    <= ok;
      end
    end
  end

  assign out_strobe    = strobe_r;
  assign out_ok        = ok_r;
  assign out_value_out = VALUE_W'(tap_or);
  assign out_count     = COUNT_W'(count_r);

endmodule
